>>> rtl/flow_controlled_byte_fifo_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the byte FIFO RTL (used by fcbf_front)
// Each macro expands to one labeled concurrent assertion on clk / rst_n.
// ---------------------------------------------------------------------------
`ifndef FLOW_CONTROLLED_BYTE_FIFO_TOP_ASSERT_SVH
`define FLOW_CONTROLLED_BYTE_FIFO_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define FCBF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define FCBF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/fcbf_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fcbf_pkg
// Shared types and constants for the flow-controlled byte FIFO.
// ---------------------------------------------------------------------------
package fcbf_pkg;

  // Fixed field widths of the stream payloads
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 13;
  localparam int CMD_W  = 3;

  // Default sizing of the top level
  localparam int DEPTH_DEF       = 4096;
  localparam int COUNT_WIDTH_DEF = 48;

  // Status queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Capacity register value after reset
  localparam logic [LEN_W-1:0] CAP_RESET = 13'd4096;

  // Input tdata: write_data, amount, zero fill to whole bytes
  localparam int IN_TDATA_W = ((BYTE_W + LEN_W + 7) / 8) * 8;

  // Command codes carried on in_tuser
  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 3'd0,
    CMD_READ  = 3'd1,
    CMD_PEEK  = 3'd2,
    CMD_POP   = 3'd3,
    CMD_END   = 3'd4
  } fcbf_cmd_t;

  // Per-transaction status handed from front to back
  typedef struct packed {
    logic              eof;
    logic              ended;
    logic [LEN_W-1:0]  room;
    logic [LEN_W-1:0]  fill;
    logic              acc;
    logic              vld;
    logic [BYTE_W-1:0] data;
  } fcbf_stat_t;

endpackage

>>> rtl/fcbf_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fcbf_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module fcbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/fcbf_front.sv
`timescale 1ns / 1ps
`include "flow_controlled_byte_fifo_top_assert.svh"
// ---------------------------------------------------------------------------
// fcbf_front
// Accepts commands, owns the buffer state and the byte store, and pushes one
// status record per transaction into the status queue.
// ---------------------------------------------------------------------------
module fcbf_front import fcbf_pkg::*; #(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [LEN_W-1:0]               cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [IN_TDATA_W-1:0]          in_tdata,
  input  logic [CMD_W-1:0]               in_tuser,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count,
  output logic                           q_push,
  output fcbf_stat_t                     q_stat,
  output logic [COUNT_WIDTH-1:0]         q_wcnt,
  output logic [COUNT_WIDTH-1:0]         q_rcnt
);

  localparam int AW  = $clog2(DEPTH);
  localparam int FW  = $clog2(DEPTH + 1);
  localparam int SW  = FW + 1;
  localparam int EW  = (FW > LEN_W) ? FW : LEN_W;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  // State
  logic [LEN_W-1:0]       cap_r;
  logic [AW-1:0]          head_r, head_nxt;
  logic [FW-1:0]          fill_r, fill_nxt;
  logic                   end_r, end_nxt;
  logic [COUNT_WIDTH-1:0] wcnt_r, wcnt_nxt;
  logic [COUNT_WIDTH-1:0] rcnt_r, rcnt_nxt;
  logic                   s1_vld_r, s1_rd_r, s1_acc_r;
  logic                   rd_nxt, acc_nxt;

  // Decode and datapath
  fcbf_cmd_t              cmd;
  logic                   in_fire;
  logic [BYTE_W-1:0]      wr_byte;
  logic [LEN_W-1:0]       amount;
  logic [FW-1:0]          cap_eff;
  logic                   amt_lt_fill;
  logic [FW-1:0]          amt_fw, pop_n, add_n, drop_n;
  logic [SW-1:0]          addr_sum;
  logic [AW-1:0]          addr;
  logic [COUNT_WIDTH:0]   wsum, rsum;
  logic [COUNT_WIDTH-1:0] wsat, rsat;
  logic                   wr_ok;
  logic [FW-1:0]          room_full;

  // Store ports
  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [BYTE_W-1:0]      ram_rdata;

  // Credit: every accepted transaction has a queue slot waiting
  assign in_tready = ((QCW + 1)'(q_count) + (QCW + 1)'(s1_vld_r)) < (QCW + 1)'(QUEUE_DEPTH);
  assign in_fire   = in_tvalid && in_tready;
  assign cmd       = fcbf_cmd_t'(in_tuser);
  assign wr_byte   = in_tdata[BYTE_W-1:0];
  assign amount    = in_tdata[BYTE_W +: LEN_W];

  // Capacity clipped to the store depth
  assign cap_eff = (EW'(cap_r) > EW'(DEPTH)) ? FW'(DEPTH) : FW'(cap_r);

  assign amt_lt_fill = EW'(amount) < EW'(fill_r);
  assign amt_fw      = FW'(amount);
  assign pop_n       = amt_lt_fill ? amt_fw : fill_r;

  // Offset and drop count per command (one shared address adder)
  always_comb begin
    add_n  = '0;
    drop_n = '0;
    case (cmd)
      CMD_WRITE: add_n = fill_r;
      CMD_READ: begin
        add_n  = FW'(1);
        drop_n = FW'(1);
      end
      CMD_PEEK:  add_n = amt_fw;
      CMD_POP: begin
        add_n  = pop_n;
        drop_n = pop_n;
      end
      default: begin
        add_n  = '0;
        drop_n = '0;
      end
    endcase
  end

  // head + offset, wrapped at DEPTH (sum is below twice DEPTH)
  assign addr_sum = SW'(head_r) + SW'(add_n);
  assign addr     = (addr_sum >= SW'(DEPTH)) ? AW'(addr_sum - SW'(DEPTH)) : AW'(addr_sum);

  // Saturating counters: carry out means the maximum was passed
  assign wsum = {1'b0, wcnt_r} + (COUNT_WIDTH + 1)'(1);
  assign rsum = {1'b0, rcnt_r} + (COUNT_WIDTH + 1)'(drop_n);
  assign wsat = wsum[COUNT_WIDTH] ? '1 : wsum[COUNT_WIDTH-1:0];
  assign rsat = rsum[COUNT_WIDTH] ? '1 : rsum[COUNT_WIDTH-1:0];

  assign wr_ok = in_fire && (cmd == CMD_WRITE) && (fill_r < cap_eff);

  // Command execution
  always_comb begin
    head_nxt  = head_r;
    fill_nxt  = fill_r;
    end_nxt   = end_r;
    wcnt_nxt  = wcnt_r;
    rcnt_nxt  = rcnt_r;
    rd_nxt    = 1'b0;
    acc_nxt   = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = addr;
    ram_raddr = addr;
    if (in_fire) begin
      case (cmd)
        CMD_WRITE: begin
          if (wr_ok) begin
            ram_we   = 1'b1;
            fill_nxt = fill_r + FW'(1);
            wcnt_nxt = wsat;
            acc_nxt  = 1'b1;
          end
        end
        CMD_READ: begin
          if (fill_r != '0) begin
            ram_re    = 1'b1;
            ram_raddr = head_r;
            head_nxt  = addr;
            fill_nxt  = fill_r - drop_n;
            rcnt_nxt  = rsat;
            rd_nxt    = 1'b1;
          end
        end
        CMD_PEEK: begin
          if (amt_lt_fill) begin
            ram_re = 1'b1;
            rd_nxt = 1'b1;
          end
        end
        CMD_POP: begin
          head_nxt = addr;
          fill_nxt = fill_r - drop_n;
          rcnt_nxt = rsat;
        end
        CMD_END: end_nxt = 1'b1;
        default: begin
          head_nxt = head_r;
        end
      endcase
    end
  end

  // State and stage-one registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= CAP_RESET;
      head_r   <= '0;
      fill_r   <= '0;
      end_r    <= 1'b0;
      wcnt_r   <= '0;
      rcnt_r   <= '0;
      s1_vld_r <= 1'b0;
      s1_rd_r  <= 1'b0;
      s1_acc_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      head_r   <= head_nxt;
      fill_r   <= fill_nxt;
      end_r    <= end_nxt;
      wcnt_r   <= wcnt_nxt;
      rcnt_r   <= rcnt_nxt;
      s1_vld_r <= in_fire;
      s1_rd_r  <= rd_nxt;
      s1_acc_r <= acc_nxt;
    end
  end

  // Byte store
  fcbf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Status record: state registers already hold the post-transaction values
  assign room_full = (cap_eff > fill_r) ? (cap_eff - fill_r) : '0;

  always_comb begin
    q_stat.data  = s1_rd_r ? ram_rdata : '0;
    q_stat.vld   = s1_rd_r;
    q_stat.acc   = s1_acc_r;
    q_stat.fill  = LEN_W'(fill_r);
    q_stat.room  = LEN_W'(room_full);
    q_stat.ended = end_r;
    q_stat.eof   = end_r && (fill_r == '0);
  end

  assign q_push = s1_vld_r;
  assign q_wcnt = wcnt_r;
  assign q_rcnt = rcnt_r;

  // Checks
  `FCBF_ASSERT_SAME(a_fill_bound, 1'b1, fill_r <= FW'(DEPTH), "fill exceeds store depth")
  `FCBF_ASSERT_SAME(a_head_bound, 1'b1, SW'(head_r) < SW'(DEPTH), "head index out of range")
  `FCBF_ASSERT_NEXT(a_wr_fill, wr_ok, fill_r == $past(fill_r) + FW'(1), "write did not grow fill")
  `FCBF_ASSERT_SAME(a_q_credit, s1_vld_r, q_count < QCW'(QUEUE_DEPTH), "status queue overrun")

endmodule

>>> rtl/fcbf_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fcbf_queue
// Small first-word-fall-through queue decoupling front from back.
// ---------------------------------------------------------------------------
module fcbf_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           din,
  input  logic                       pop,
  output logic [WIDTH-1:0]           dout,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wptr_r, rptr_r;
  logic [CW-1:0]    count_r;

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= din;
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
      end
      if (pop) begin
        rptr_r <= (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + CW'(1);
        2'b01:   count_r <= count_r - CW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  assign dout  = slot_r[rptr_r];
  assign count = count_r;

endmodule

>>> rtl/fcbf_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fcbf_back
// Drains the status queue into the result output register and packs tdata.
// ---------------------------------------------------------------------------
module fcbf_back import fcbf_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_nonempty,
  input  fcbf_stat_t                q_stat,
  input  logic [COUNT_WIDTH-1:0]    q_wcnt,
  input  logic [COUNT_WIDTH-1:0]    q_rcnt,
  output logic                      q_pop,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [((BYTE_W + 2 * LEN_W + 3 + 2 * COUNT_WIDTH + 7) / 8) * 8 - 1:0] out_tdata,
  output logic                      out_tuser
);

  // byte, accepted, fill, room, ended, at_eof, two counts
  localparam int USED_W = BYTE_W + 1 + 2 * LEN_W + 2 + 2 * COUNT_WIDTH;
  localparam int TDW    = ((BYTE_W + 2 * LEN_W + 3 + 2 * COUNT_WIDTH + 7) / 8) * 8;
  localparam int PAD_W  = TDW - USED_W;

  logic           vld_r;
  logic [TDW-1:0] data_r, data_nxt;
  logic           user_r;

  // Refill the output register when it is empty or being taken
  assign q_pop = q_nonempty && (!vld_r || out_tready);

  assign data_nxt = {{PAD_W{1'b0}}, q_rcnt, q_wcnt, q_stat.eof, q_stat.ended,
                     q_stat.room, q_stat.fill, q_stat.acc, q_stat.data};

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (q_pop) begin
      vld_r <= 1'b1;
    end else if (out_tready) begin
      vld_r <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      data_r <= data_nxt;
      user_r <= q_stat.vld;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;

endmodule

>>> rtl/flow_controlled_byte_fifo_top.sv
`timescale 1ns / 1ps
// Byte FIFO with a programmable capacity and an end-of-input flag.
// Input channel (in_*): one command per transaction: write a byte, read the
// head byte, peek at an offset behind the head, pop up to a count of bytes,
// or mark end of input. Every command yields exactly one result transaction.
// Result channel (out_*): the byte read or peeked (zero when none), the
// write-accepted flag, fill, room, ended, end of stream, and saturating
// counts of bytes written and read.
// Configuration: cfg_we with cfg_wdata writes the capacity (clipped to
// DEPTH); write it only while no transaction is in flight.
// A result passes the stage-one registers, status queue and output register.
// Throughput: one command per cycle while out_tready is high; the store
// serves at most one byte access per command.
// Reset clears fill, head, counts and the end flag and sets capacity to 4096;
// the byte store is not cleared, as only written bytes are ever read.
// When the receiver stalls, up to four results wait in the status queue
// behind the one in the output register; in_tready falls once that room is
// spoken for.
// ---------------------------------------------------------------------------
// flow_controlled_byte_fifo_top
// Top level: command front end, status queue and result back end.
// ---------------------------------------------------------------------------
module flow_controlled_byte_fifo_top import fcbf_pkg::*; #(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [LEN_W-1:0]      cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [7:0] write_data, [20:8] amount, [23:21] zero
  input  logic [IN_TDATA_W-1:0] in_tdata,
  // [2:0] cmd
  input  logic [CMD_W-1:0]      in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [7:0] out_byte, [8] accepted, [21:9] fill, [34:22] room, [35] ended,
  // [36] at_eof, then total_written and total_read (COUNT_WIDTH each), zero
  output logic [((BYTE_W + 2 * LEN_W + 3 + 2 * COUNT_WIDTH + 7) / 8) * 8 - 1:0] out_tdata,
  // [0] out_valid
  output logic                  out_tuser
);

  localparam int QW  = $bits(fcbf_stat_t) + 2 * COUNT_WIDTH;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  logic                   q_push, q_pop;
  fcbf_stat_t             push_stat;
  logic [COUNT_WIDTH-1:0] push_wcnt, push_rcnt;
  logic [QW-1:0]          q_din, q_dout;
  logic [QCW-1:0]         q_count;

  // Front: command decode, state and store
  fcbf_front #(
    .DEPTH       (DEPTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_count   (q_count),
    .q_push    (q_push),
    .q_stat    (push_stat),
    .q_wcnt    (push_wcnt),
    .q_rcnt    (push_rcnt)
  );

  assign q_din = {push_rcnt, push_wcnt, push_stat};

  // Status queue
  fcbf_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .count (q_count)
  );

  // Back: result register
  fcbf_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_count != '0),
    .q_stat     (fcbf_stat_t'(q_dout[$bits(fcbf_stat_t)-1:0])),
    .q_wcnt     (q_dout[$bits(fcbf_stat_t) +: COUNT_WIDTH]),
    .q_rcnt     (q_dout[$bits(fcbf_stat_t) + COUNT_WIDTH +: COUNT_WIDTH]),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
